### design/cle_pkg.sv
// shared constants, codes and structs for the cursor list engine
`timescale 1ns / 1ps

package cle_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int KIND_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = 2;
  localparam int LIMIT_W = 5;
  localparam int POS_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    OP_INSERT  = 4'd0,
    OP_REMOVE  = 4'd1,
    OP_REPLACE = 4'd2,
    OP_CLEAR   = 4'd3,
    OP_BEGIN   = 4'd4,
    OP_END     = 4'd5,
    OP_NEXT    = 4'd6,
    OP_PRIOR   = 4'd7,
    OP_READ    = 4'd8
  } kind_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic               rep;
    logic [COUNT_W-1:0] ins_at;
    logic [IDX_W-1:0]   pos;
    logic [COUNT_W-1:0] cnt;
  } cle_cmd_t;

  // status of the operation being taken
  typedef struct packed {
    logic [COUNT_W-1:0] count_d;
    logic [IDX_W-1:0]   pos_d;
    err_e               err;
    logic               moved;
  } cle_stat_t;

endpackage

### design/cursor_list_engine_core.sv
// top level: controller, chain of list cells and result register
// a result is registered and valid in the cycle after its input transfer
// throughput: one operation per cycle while no stalled result holds the input back;
// every shift happens in the cell chain at once, and the chain itself never stalls
// reset: count 0, cursor -1, capacity limit 16, no result pending
// entries are not cleared at reset; only written entries are ever reported
`timescale 1ns / 1ps

module cursor_list_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cle_pkg::LIMIT_W-1:0] cfg_capacity_limit_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cle_pkg::KIND_W-1:0]  kind_i,
  input  logic [cle_pkg::DATA_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cle_pkg::DATA_W-1:0]  item_at_cursor_o,
  output logic [cle_pkg::ERR_W-1:0]   error_code_o,
  output logic                        moved_o,
  output logic [cle_pkg::COUNT_W-1:0] entry_count_o,
  output logic [cle_pkg::POS_W-1:0]   cursor_position_o
);

  logic [cle_pkg::LIMIT_W-1:0] limit_q;
  logic                        accept;
  logic                        out_valid_q;
  logic [cle_pkg::DATA_W-1:0]  item_q;
  logic [cle_pkg::DATA_W-1:0]  item_d;
  logic [cle_pkg::ERR_W-1:0]   err_q;
  logic                        moved_q;
  logic [cle_pkg::COUNT_W-1:0] count_q;
  logic [cle_pkg::POS_W-1:0]   pos_q;
  logic [cle_pkg::POS_W-1:0]   pos_d;
  cle_pkg::cle_cmd_t           cmd;
  cle_pkg::cle_stat_t          stat;
  logic [cle_pkg::DATA_W-1:0]  cell_data [cle_pkg::CAPACITY];
  logic [cle_pkg::DATA_W-1:0]  cell_next [cle_pkg::CAPACITY];

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cle_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_capacity_limit_i;
    end
  end

  // input transfer whenever the result register is free or being emptied
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  cle_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .limit_i  (limit_q),
    .cmd_o    (cmd),
    .stat_o   (stat)
  );

  // chain of cells
  for (genvar g = 0; g < cle_pkg::CAPACITY; g++) begin : g_cell
    logic [cle_pkg::DATA_W-1:0] left;
    logic [cle_pkg::DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[g-1];
    end
    if (g == cle_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[g+1];
    end
    cle_cell u_cell (
      .clk_i   (clk_i),
      .index_i (cle_pkg::IDX_W'(g)),
      .cmd_i   (cmd),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .next_o  (cell_next[g])
    );
  end

  // entry under the new cursor, zero when the list ends up empty
  assign item_d = (stat.count_d == '0) ? '0 : cell_next[stat.pos_d];
  assign pos_d  = (stat.count_d == '0) ? '1 : cle_pkg::POS_W'(stat.pos_d);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= item_d;
      err_q   <= stat.err;
      moved_q <= stat.moved;
      count_q <= stat.count_d;
      pos_q   <= pos_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign item_at_cursor_o  = item_q;
  assign error_code_o      = err_q;
  assign moved_o           = moved_q;
  assign entry_count_o     = count_q;
  assign cursor_position_o = pos_q;

`ifndef SYNTHESIS
  // every input transfer leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("no result after input transfer");

  // the count never runs past the list size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> int'(count_q) <= cle_pkg::CAPACITY)
    else $error("entry count beyond capacity");

  // the cursor is -1 exactly when the list is empty
  a_cursor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((count_q == '0) == (pos_q == '1)))
    else $error("cursor and count disagree");

  // a cursor move never comes with an error
  a_moved_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && moved_q) |-> (err_q == cle_pkg::ERR_NONE))
    else $error("moved flag set with an error");
`endif

endmodule

### design/cle_cell.sv
// one storage cell of the list chain, shifting to or from its neighbours
`timescale 1ns / 1ps

module cle_cell (
  input  logic                       clk_i,
  input  logic [cle_pkg::IDX_W-1:0]  index_i,
  input  cle_pkg::cle_cmd_t          cmd_i,
  input  logic [cle_pkg::DATA_W-1:0] value_i,
  input  logic [cle_pkg::DATA_W-1:0] left_i,
  input  logic [cle_pkg::DATA_W-1:0] right_i,
  output logic [cle_pkg::DATA_W-1:0] data_o,
  output logic [cle_pkg::DATA_W-1:0] next_o
);

  logic [cle_pkg::DATA_W-1:0]  data_q;
  logic [cle_pkg::DATA_W-1:0]  data_d;
  logic [cle_pkg::COUNT_W-1:0] idx;
  logic [cle_pkg::COUNT_W-1:0] pos;

  assign idx = cle_pkg::COUNT_W'(index_i);
  assign pos = cle_pkg::COUNT_W'(cmd_i.pos);

  // pick own, left, right or new word
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx == cmd_i.ins_at) begin
        data_d = value_i;
      end else if (idx > cmd_i.ins_at && idx <= cmd_i.cnt) begin
        data_d = left_i;
      end
    end
    if (cmd_i.rem && idx >= pos && (idx + 1'b1) < cmd_i.cnt) begin
      data_d = right_i;
    end
    if (cmd_i.rep && idx == pos) begin
      data_d = value_i;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

### design/cle_ctrl.sv
// operation decode, count and cursor registers, cell command broadcast
`timescale 1ns / 1ps

module cle_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [cle_pkg::KIND_W-1:0]  kind_i,
  input  logic [cle_pkg::LIMIT_W-1:0] limit_i,
  output cle_pkg::cle_cmd_t           cmd_o,
  output cle_pkg::cle_stat_t          stat_o
);

  logic [cle_pkg::COUNT_W-1:0] count_q;
  logic [cle_pkg::COUNT_W-1:0] count_d;
  logic [cle_pkg::IDX_W-1:0]   pos_q;
  logic [cle_pkg::IDX_W-1:0]   pos_d;
  logic [cle_pkg::COUNT_W-1:0] lim_eff;
  logic [cle_pkg::COUNT_W-1:0] last;
  logic [cle_pkg::COUNT_W-1:0] pos_w;
  logic [cle_pkg::COUNT_W-1:0] ins_at;
  logic                        empty;
  logic                        ins;
  logic                        rem;
  logic                        rep;
  logic                        moved;
  cle_pkg::err_e               err;

  // clamp the configured limit to 1..CAPACITY
  always_comb begin
    if (limit_i == '0) begin
      lim_eff = cle_pkg::COUNT_W'(1);
    end else if (int'(limit_i) > cle_pkg::CAPACITY) begin
      lim_eff = cle_pkg::COUNT_W'(cle_pkg::CAPACITY);
    end else begin
      lim_eff = cle_pkg::COUNT_W'(limit_i);
    end
  end

  assign empty  = (count_q == '0);
  assign pos_w  = cle_pkg::COUNT_W'(pos_q);
  assign last   = count_q - 1'b1;
  assign ins_at = empty ? '0 : pos_w + 1'b1;

  // operation decode
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    err     = cle_pkg::ERR_NONE;
    moved   = 1'b0;
    ins     = 1'b0;
    rem     = 1'b0;
    rep     = 1'b0;
    if (kind_i == cle_pkg::OP_INSERT) begin
      if (count_q >= lim_eff) begin
        err = cle_pkg::ERR_FULL;
      end else begin
        ins     = 1'b1;
        count_d = count_q + 1'b1;
        pos_d   = ins_at[cle_pkg::IDX_W-1:0];
      end
    end else if (kind_i == cle_pkg::OP_CLEAR) begin
      count_d = '0;
      pos_d   = '0;
    end else if (kind_i <= cle_pkg::OP_READ && empty) begin
      err = cle_pkg::ERR_EMPTY;
    end else begin
      unique case (kind_i)
        cle_pkg::OP_REMOVE: begin
          count_d = last;
          if (pos_w == last) begin
            pos_d = '0;
          end else begin
            rem = 1'b1;
          end
        end
        cle_pkg::OP_REPLACE: rep = 1'b1;
        cle_pkg::OP_BEGIN:   pos_d = '0;
        cle_pkg::OP_END:     pos_d = last[cle_pkg::IDX_W-1:0];
        cle_pkg::OP_NEXT: begin
          if (pos_w < last) begin
            pos_d = pos_q + 1'b1;
            moved = 1'b1;
          end
        end
        cle_pkg::OP_PRIOR: begin
          if (pos_q != '0) begin
            pos_d = pos_q - 1'b1;
            moved = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // count and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // cell commands only act on an accepted transfer
  assign cmd_o.ins    = ins & accept_i;
  assign cmd_o.rem    = rem & accept_i;
  assign cmd_o.rep    = rep & accept_i;
  assign cmd_o.ins_at = ins_at;
  assign cmd_o.pos    = pos_q;
  assign cmd_o.cnt    = count_q;

  assign stat_o.count_d = count_d;
  assign stat_o.pos_d   = pos_d;
  assign stat_o.err     = err;
  assign stat_o.moved   = moved;

endmodule
